/* hdl/sparse_coverage_mask_decoder_defines.svh */
// Assertion macros shared by the sparse coverage mask decoder RTL.
`ifndef SPARSE_COVERAGE_MASK_DECODER_DEFINES_SVH
`define SPARSE_COVERAGE_MASK_DECODER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SCMD_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SCMD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/scmd_pkg.sv */
// Shared types and constants of the sparse coverage mask decoder.
package scmd_pkg;

  localparam int ColumnBits = 12;
  localparam int MaskWidthW = 12;
  localparam int MaskHeightW = 8;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW = 16;
  localparam int QueueDepth = 4;
  localparam int QPtrW = $clog2(QueueDepth);

  localparam logic [CfgIndexW-1:0] CFG_BOUNDS_X = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_BOUNDS_Y = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_MASK_WIDTH = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_MASK_HEIGHT = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_CLIP_LEFT = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_CLIP_TOP = 3'd5;
  localparam logic [CfgIndexW-1:0] CFG_CLIP_RIGHT = 3'd6;
  localparam logic [CfgIndexW-1:0] CFG_CLIP_BOTTOM = 3'd7;

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_MALFORMED = 2'd2,
    KIND_TRUNC     = 2'd3
  } kind_t;

  typedef struct packed {
    logic [15:0]            bounds_x;
    logic [15:0]            bounds_y;
    logic [MaskWidthW-1:0]  mask_width;
    logic [MaskHeightW-1:0] mask_height;
    logic [15:0]            clip_left;
    logic [15:0]            clip_top;
    logic [15:0]            clip_right;
    logic [15:0]            clip_bottom;
  } cfg_t;

  // One decoded byte: up to four pixel rows and an optional closing status.
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y0;
    logic [7:0]  codes;
    logic [2:0]  count;
    logic        has_status;
    kind_t       kind;
  } job_t;

endpackage

/* hdl/scmd_front.sv */
// Byte parser: walks the mask header and column runs, emits one job per byte that yields rows or a status.
module scmd_front (
  input  logic          clk,
  input  logic          rst,
  input  scmd_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          first_byte,
  input  logic          end_of_text,
  input  logic          q_full,
  output logic          push,
  output scmd_pkg::job_t push_job
);
  import scmd_pkg::*;

  localparam int CmpW = (ColumnBits + 1 > MaskWidthW) ? ColumnBits + 1 : MaskWidthW;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_LEN_HI = 5'b00010,
    PH_START  = 5'b00100,
    PH_RUN    = 5'b01000,
    PH_PACKED = 5'b10000
  } phase_t;

  phase_t                phase, phase_next;
  logic [7:0]            length_low, length_low_next;
  logic [15:0]           bytes_left, bytes_left_next;
  logic [ColumnBits-1:0] column_index, column_index_next;
  logic [7:0]            start_row, start_row_next;
  logic [7:0]            run_rows, run_rows_next;
  logic [7:0]            rows_done, rows_done_next;

  logic                  accept;
  logic [15:0]           bl_dec;
  logic [ColumnBits:0]   col_nxt;
  logic                  col_end;
  logic [7:0]            rows_rem;
  logic [2:0]            row_cnt;
  logic [6:0]            packed_need;
  job_t                  job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    bl_dec      = (bytes_left != 16'd0) ? bytes_left - 16'd1 : bytes_left;
    col_nxt     = {1'b0, column_index} + {{ColumnBits{1'b0}}, 1'b1};
    // column limit, counter overflow or count too short for another header
    col_end     = (CmpW'(col_nxt) >= CmpW'(cfg.mask_width)) || col_nxt[ColumnBits] ||
                  (bl_dec < 16'd2);
    rows_rem    = run_rows - rows_done;
    row_cnt     = (rows_rem >= 8'd4) ? 3'd4 : rows_rem[2:0];
    packed_need = 7'(({1'b0, data_byte} + 9'd3) >> 2);

    phase_next        = phase;
    length_low_next   = length_low;
    bytes_left_next   = bytes_left;
    column_index_next = column_index;
    start_row_next    = start_row;
    run_rows_next     = run_rows;
    rows_done_next    = rows_done;

    job            = '0;
    job.x          = cfg.bounds_x + 16'(column_index);
    job.y0         = cfg.bounds_y + {8'd0, start_row} + {8'd0, rows_done};
    job.codes      = data_byte;
    job.kind       = KIND_DONE;

    if (first_byte) begin
      phase_next        = PH_LEN_HI;
      length_low_next   = data_byte;
      bytes_left_next   = '0;
      column_index_next = '0;
      start_row_next    = '0;
      run_rows_next     = '0;
      rows_done_next    = '0;
    end else begin
      unique case (phase)
        PH_LEN_HI: begin
          bytes_left_next   = {data_byte, length_low};
          column_index_next = '0;
          if (cfg.mask_width == '0 || cfg.mask_height == '0 ||
              {data_byte, length_low} < 16'd2) begin
            job.has_status = 1'b1;
            job.kind       = KIND_DONE;
            phase_next     = PH_IDLE;
          end else begin
            phase_next = PH_START;
          end
        end
        PH_START: begin
          start_row_next  = data_byte;
          bytes_left_next = bl_dec;
          phase_next      = PH_RUN;
        end
        PH_RUN: begin
          run_rows_next   = data_byte;
          bytes_left_next = bl_dec;
          if (start_row == 8'hFF && data_byte == 8'd0) begin
            // skip pair: move straight to the next column
            if (col_end) begin
              job.has_status = 1'b1;
              job.kind       = KIND_DONE;
              phase_next     = PH_IDLE;
            end else begin
              column_index_next = col_nxt[ColumnBits-1:0];
              phase_next        = PH_START;
            end
          end else if (start_row >= cfg.mask_height || data_byte == 8'd0 ||
                       data_byte > cfg.mask_height - start_row ||
                       {9'd0, packed_need} > bl_dec) begin
            job.has_status = 1'b1;
            job.kind       = KIND_MALFORMED;
            phase_next     = PH_IDLE;
          end else begin
            rows_done_next = '0;
            phase_next     = PH_PACKED;
          end
        end
        PH_PACKED: begin
          job.count       = row_cnt;
          rows_done_next  = rows_done + {5'd0, row_cnt};
          bytes_left_next = bl_dec;
          if (rows_done + {5'd0, row_cnt} >= run_rows) begin
            if (col_end) begin
              job.has_status = 1'b1;
              job.kind       = KIND_DONE;
              phase_next     = PH_IDLE;
            end else begin
              column_index_next = col_nxt[ColumnBits-1:0];
              phase_next        = PH_START;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end

    // stream ended while the mask still wanted bytes
    if (end_of_text && phase_next != PH_IDLE) begin
      job.has_status = 1'b1;
      job.kind       = KIND_TRUNC;
      phase_next     = PH_IDLE;
    end
  end

  assign push     = accept && (job.count != 3'd0 || job.has_status);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      length_low   <= length_low_next;
      bytes_left   <= bytes_left_next;
      column_index <= column_index_next;
      start_row    <= start_row_next;
      run_rows     <= run_rows_next;
      rows_done    <= rows_done_next;
    end
  end

endmodule

/* hdl/scmd_fifo.sv */
// Short job queue between the byte parser and the result sequencer.
module scmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scmd_pkg::job_t push_job,
  input  logic           pop,
  output scmd_pkg::job_t head,
  output logic           full,
  output logic           empty
);
  import scmd_pkg::*;

  job_t             mem [QueueDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QPtrW:0]   fill, fill_next;

  assign full  = (fill == (QPtrW+1)'(QueueDepth));
  assign empty = (fill == '0);
  assign head  = mem[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push && !pop) begin
      fill_next = fill + (QPtrW+1)'(1);
    end else if (pop && !push) begin
      fill_next = fill - (QPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

/* hdl/scmd_back.sv */
// Result sequencer: clips job rows and sends one result word per cycle while out_ready holds.
module scmd_back (
  input  logic           clk,
  input  logic           rst,
  input  scmd_pkg::cfg_t cfg,
  input  scmd_pkg::job_t head,
  input  logic           q_empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     result_kind,
  output logic [15:0]    pixel_x,
  output logic [15:0]    pixel_y,
  output logic [2:0]     coverage,
  output logic           last_of_run
);
  import scmd_pkg::*;
  `include "sparse_coverage_mask_decoder_defines.svh"

  logic        work_valid;
  logic [15:0] work_x;
  logic [15:0] work_y0;
  logic [7:0]  work_codes;
  logic [3:0]  work_mask;
  logic        work_has_status;
  kind_t       work_kind;

  logic [3:0][15:0] load_y;
  logic [3:0]  load_mask;
  logic        x_in;
  logic [3:0]  low_bit;
  logic [3:0]  mask_rest;
  logic [1:0]  sel_idx;
  logic        advance, emit, work_done, load_keep;

  // clip test done once as the job leaves the queue
  always_comb begin
    x_in = ($signed(head.x) >= $signed(cfg.clip_left)) &&
           ($signed(head.x) < $signed(cfg.clip_right));
    for (int i = 0; i < 4; i++) begin
      load_y[i]    = head.y0 + 16'(i);
      load_mask[i] = (3'(i) < head.count) && x_in &&
                     ($signed(load_y[i]) >= $signed(cfg.clip_top)) &&
                     ($signed(load_y[i]) < $signed(cfg.clip_bottom));
    end
  end

  assign low_bit   = work_mask & (~work_mask + 4'd1);
  assign mask_rest = work_mask & ~low_bit;

  always_comb begin
    priority if (work_mask[0]) sel_idx = 2'd0;
    else if (work_mask[1])     sel_idx = 2'd1;
    else if (work_mask[2])     sel_idx = 2'd2;
    else                       sel_idx = 2'd3;
  end

  assign advance   = !out_valid || out_ready;
  assign emit      = advance && work_valid;
  assign work_done = emit && (work_mask == 4'd0 || (mask_rest == 4'd0 && !work_has_status));
  assign pop       = (!work_valid || work_done) && !q_empty;
  assign load_keep = load_mask != 4'd0 || head.has_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        work_valid <= load_keep;
      end else if (work_done) begin
        work_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work_x          <= head.x;
      work_y0         <= head.y0;
      work_codes      <= head.codes;
      work_mask       <= load_mask;
      work_has_status <= head.has_status;
      work_kind       <= head.kind;
    end else if (emit) begin
      work_mask <= mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (work_mask != 4'd0) begin
        result_kind <= KIND_PIXEL;
        pixel_x     <= work_x;
        pixel_y     <= work_y0 + 16'(sel_idx);
        coverage    <= {1'b0, work_codes[{sel_idx, 1'b0} +: 2]} + 3'd1;
        last_of_run <= (mask_rest == 4'd0) && !work_has_status;
      end else begin
        result_kind <= work_kind;
        pixel_x     <= '0;
        pixel_y     <= '0;
        coverage    <= '0;
        last_of_run <= 1'b1;
      end
    end
  end

  `SCMD_ASSERT_IMPLY(a_pixel_cov, out_valid && result_kind == KIND_PIXEL, coverage != 3'd0, "pixel word without coverage")
  `SCMD_ASSERT_IMPLY(a_status_last, out_valid && result_kind != KIND_PIXEL, last_of_run && coverage == 3'd0, "status word not closing its byte")
  `SCMD_ASSERT_IMPLY(a_work_nonempty, work_valid, work_mask != 4'd0 || work_has_status, "held job has nothing left to send")
  `SCMD_ASSERT_NEXT(a_emit_valid, emit, out_valid, "emitted word not presented")

endmodule

/* hdl/sparse_coverage_mask_decoder.sv */
// Top level of the sparse coverage mask decoder: config registers, parser, queue, sequencer.
// A byte's job passes through the job queue and the sequencer's work registers; result words are registered.
// Throughput: the parser takes one byte word per cycle while the 4-deep job queue has room;
//   the sequencer sends one result word per cycle while out_ready holds, so a packed byte yields
//   one word per unclipped pixel plus any status; fully clipped bytes without status yield none.
// Reset (rst, synchronous): parser idle, queue and output empty, config registers zero.
module sparse_coverage_mask_decoder (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [scmd_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [scmd_pkg::CfgDataW-1:0]  cfg_data,
  // mask byte words in
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           first_byte,
  input  logic                           end_of_text,
  // result words out
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     result_kind,
  output logic signed [15:0]             pixel_x,
  output logic signed [15:0]             pixel_y,
  output logic [2:0]                     coverage,
  output logic                           last_of_run
);
  import scmd_pkg::*;

  cfg_t cfg;
  logic push, pop, q_full, q_empty;
  job_t push_job, head;
  logic [15:0] px, py;

  // Config registers. The user must write them only while the decoder is idle (the block does not
  // enforce this), so the parser and sequencer read them directly without any shadowing.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOUNDS_X:    cfg.bounds_x    <= cfg_data;
        CFG_BOUNDS_Y:    cfg.bounds_y    <= cfg_data;
        CFG_MASK_WIDTH:  cfg.mask_width  <= cfg_data[MaskWidthW-1:0];
        CFG_MASK_HEIGHT: cfg.mask_height <= cfg_data[MaskHeightW-1:0];
        CFG_CLIP_LEFT:   cfg.clip_left   <= cfg_data;
        CFG_CLIP_TOP:    cfg.clip_top    <= cfg_data;
        CFG_CLIP_RIGHT:  cfg.clip_right  <= cfg_data;
        CFG_CLIP_BOTTOM: cfg.clip_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: header/run parsing, one byte word per cycle while the queue has room. Each byte that can
  // yield a result becomes one job (up to four rows plus an optional status).
  scmd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .first_byte  (first_byte),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  // Queue decouples parsing from result delivery so either side may stall.
  scmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back: clips rows and serialises the job into registered result words.
  scmd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .pixel_x     (px),
    .pixel_y     (py),
    .coverage    (coverage),
    .last_of_run (last_of_run)
  );

  assign pixel_x = $signed(px);
  assign pixel_y = $signed(py);

endmodule
